>>> hdl/skr_pkg.sv
// ----------------------------------------------------------------------------
// skr_pkg
// Shared types, widths and helpers for the sparse Khatri-Rao join core.
// ----------------------------------------------------------------------------
package skr_pkg;

  localparam int IDX_BITS      = 16;
  localparam int VAL_BITS      = 32;
  localparam int DIM_BITS      = 17;
  localparam int OUT_IDX_BITS  = 32;
  localparam int B_ENTRIES_DEF = 64;

  // configuration register indexes
  localparam logic REG_DIM_MODE0 = 1'b0;
  localparam logic REG_DIM_MODE1 = 1'b1;

  // input op codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PRESENT = 1'b1;

  // one stored B nonzero
  typedef struct packed {
    logic [IDX_BITS-1:0]        m0;
    logic [IDX_BITS-1:0]        m1;
    logic [IDX_BITS-1:0]        sh;
    logic signed [VAL_BITS-1:0] val;
  } entry_t;

  // per-step status of the scan, handed from the cell row to the join unit
  typedef struct packed {
    logic hit;  // head entry is stored and matches the shared index
    logic fin;  // flush slot after the last entry
  } tap_t;

  // arithmetic shift of a Q16.16 product back to Q16.16, saturated to 32 bits
  function automatic logic signed [VAL_BITS-1:0] q16_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic signed [VAL_BITS-1:0] r;
    s = p >>> 16;
    if (s > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (s < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = s[VAL_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/skr_cell.sv
// ----------------------------------------------------------------------------
// skr_cell
// One slot of the B entry ring: loads a new entry or takes its neighbor's.
// ----------------------------------------------------------------------------
module skr_cell (
  input  logic            clk,
  input  logic            load,
  input  logic            shift,
  input  skr_pkg::entry_t load_in,
  input  skr_pkg::entry_t shift_in,
  output skr_pkg::entry_t entry
);

  // load wins; otherwise rotate one place toward the head, or hold
  always_ff @(posedge clk) begin
    if (load) begin
      entry <= load_in;
    end else if (shift) begin
      entry <= shift_in;
    end
  end

endmodule

>>> hdl/skr_join.sv
// ----------------------------------------------------------------------------
// skr_join
// Product pipeline: index and value multiplies, saturation, and a one-deep
// holding register that lets the final match carry the last flag.
// ----------------------------------------------------------------------------
module skr_join (
  input  logic                                    clk,
  input  logic                                    rst,
  input  skr_pkg::tap_t                           tap,
  input  skr_pkg::entry_t                         head,
  input  logic [skr_pkg::IDX_BITS-1:0]            a_m0,
  input  logic [skr_pkg::IDX_BITS-1:0]            a_m1,
  input  logic [skr_pkg::IDX_BITS-1:0]            a_sh,
  input  logic signed [skr_pkg::VAL_BITS-1:0]     a_val,
  input  logic [skr_pkg::DIM_BITS-1:0]            dim0,
  input  logic [skr_pkg::DIM_BITS-1:0]            dim1,
  output logic                                    drained,
  output logic                                    valid,
  output logic [skr_pkg::OUT_IDX_BITS-1:0]        out_idx_mode0,
  output logic [skr_pkg::OUT_IDX_BITS-1:0]        out_idx_mode1,
  output logic [skr_pkg::IDX_BITS-1:0]            out_idx_shared,
  output logic signed [skr_pkg::VAL_BITS-1:0]     out_value,
  output logic                                    last
);

  localparam int PW = skr_pkg::IDX_BITS + skr_pkg::DIM_BITS;

  // stage 1
  skr_pkg::tap_t   tap1;
  skr_pkg::entry_t ent1;
  logic [PW-1:0]   prod0;
  logic [PW-1:0]   prod1;

  // stage 2
  skr_pkg::tap_t                          tap2;
  logic signed [63:0]                     prod_val;
  logic [skr_pkg::OUT_IDX_BITS-1:0]       idx0_2;
  logic [skr_pkg::OUT_IDX_BITS-1:0]       idx1_2;

  // holding register
  logic                                   pend_v;
  logic [skr_pkg::OUT_IDX_BITS-1:0]       pend_idx0;
  logic [skr_pkg::OUT_IDX_BITS-1:0]       pend_idx1;
  logic signed [skr_pkg::VAL_BITS-1:0]    pend_val;
  logic signed [skr_pkg::VAL_BITS-1:0]    sat_val;

  // stage 1: capture the head entry and the A-side index products
  always_ff @(posedge clk) begin
    if (rst) begin
      tap1 <= '0;
    end else begin
      tap1 <= tap;
    end
  end

  always_ff @(posedge clk) begin
    ent1  <= head;
    prod0 <= PW'(a_m0) * PW'(dim0);
    prod1 <= PW'(a_m1) * PW'(dim1);
  end

  // stage 2: value multiply and combined index add
  always_ff @(posedge clk) begin
    if (rst) begin
      tap2 <= '0;
    end else begin
      tap2 <= tap1;
    end
  end

  always_ff @(posedge clk) begin
    prod_val <= 64'(a_val) * 64'(ent1.val);
    idx0_2   <= prod0[skr_pkg::OUT_IDX_BITS-1:0]
                + {{(skr_pkg::OUT_IDX_BITS-skr_pkg::IDX_BITS){1'b0}}, ent1.m0};
    idx1_2   <= prod1[skr_pkg::OUT_IDX_BITS-1:0]
                + {{(skr_pkg::OUT_IDX_BITS-skr_pkg::IDX_BITS){1'b0}}, ent1.m1};
  end

  assign sat_val = skr_pkg::q16_sat(prod_val);
  assign drained = tap2.fin;

  // hold one match back; a newer match releases it, the flush slot ends it
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      valid  <= 1'b0;
    end else if (tap2.hit) begin
      valid  <= pend_v;
      pend_v <= 1'b1;
    end else if (tap2.fin) begin
      valid  <= pend_v;
      pend_v <= 1'b0;
    end else begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tap2.hit) begin
      pend_idx0 <= idx0_2;
      pend_idx1 <= idx1_2;
      pend_val  <= sat_val;
    end
    if (tap2.hit || tap2.fin) begin
      out_idx_mode0 <= pend_idx0;
      out_idx_mode1 <= pend_idx1;
      out_value     <= pend_val;
      out_idx_shared <= a_sh;
      last          <= tap2.fin;
    end
  end

endmodule

>>> hdl/sparse_khatri_rao_join_core.sv
// ----------------------------------------------------------------------------
// sparse_khatri_rao_join_core
// A load (op 0) leaves busy low. An A item (op 1) holds busy while the ring of
// B_ENTRIES cells rotates one entry past the compare point per cycle, and then
// through one flush slot and two product stages. Matches strobe out in load
// order, one per cycle at most; the last one goes out as busy falls. The
// receiver cannot stall.
// Reset (rst, synchronous): entry count zero, dimensions one, block idle.
// ----------------------------------------------------------------------------
module sparse_khatri_rao_join_core #(
  parameter int B_ENTRIES = skr_pkg::B_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic [skr_pkg::DIM_BITS-1:0]        cfg_data,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [skr_pkg::IDX_BITS-1:0]        idx_mode0,
  input  logic [skr_pkg::IDX_BITS-1:0]        idx_mode1,
  input  logic [skr_pkg::IDX_BITS-1:0]        idx_shared,
  input  logic signed [skr_pkg::VAL_BITS-1:0] value,
  output logic                                valid,
  output logic [skr_pkg::OUT_IDX_BITS-1:0]    out_idx_mode0,
  output logic [skr_pkg::OUT_IDX_BITS-1:0]    out_idx_mode1,
  output logic [skr_pkg::IDX_BITS-1:0]        out_idx_shared,
  output logic signed [skr_pkg::VAL_BITS-1:0] out_value,
  output logic                                last
);

  localparam int CW = $clog2(B_ENTRIES + 1);

  logic [skr_pkg::DIM_BITS-1:0]        dim0;
  logic [skr_pkg::DIM_BITS-1:0]        dim1;
  logic [CW-1:0]                       count;
  logic [CW-1:0]                       step;
  logic                                scan;
  logic                                accept;
  logic                                load_go;
  logic                                shift;
  logic                                drained;
  logic [skr_pkg::IDX_BITS-1:0]        a_m0;
  logic [skr_pkg::IDX_BITS-1:0]        a_m1;
  logic [skr_pkg::IDX_BITS-1:0]        a_sh;
  logic signed [skr_pkg::VAL_BITS-1:0] a_val;
  skr_pkg::entry_t                     new_entry;
  skr_pkg::entry_t                     ring [B_ENTRIES];
  skr_pkg::tap_t                       tap;

  assign accept  = start && !busy;
  assign load_go = accept && (op == skr_pkg::OP_LOAD) && (count != CW'(B_ENTRIES));
  assign shift   = scan && (step != CW'(B_ENTRIES));

  assign new_entry.m0  = idx_mode0;
  assign new_entry.m1  = idx_mode1;
  assign new_entry.sh  = idx_shared;
  assign new_entry.val = value;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim0 <= skr_pkg::DIM_BITS'(1);
      dim1 <= skr_pkg::DIM_BITS'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        skr_pkg::REG_DIM_MODE0: dim0 <= cfg_data;
        skr_pkg::REG_DIM_MODE1: dim1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // fill count; loads past capacity are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load_go) begin
      count <= count + CW'(1);
    end
  end

  // scan control: one ring step per cycle, then a flush slot
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      scan <= 1'b0;
      step <= '0;
    end else begin
      if (accept && (op == skr_pkg::OP_PRESENT)) begin
        busy <= 1'b1;
        scan <= 1'b1;
        step <= '0;
      end else begin
        if (scan) begin
          if (step == CW'(B_ENTRIES)) begin
            scan <= 1'b0;
          end else begin
            step <= step + CW'(1);
          end
        end
        if (drained) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // hold the A nonzero for the whole scan
  always_ff @(posedge clk) begin
    if (accept && (op == skr_pkg::OP_PRESENT)) begin
      a_m0  <= idx_mode0;
      a_m1  <= idx_mode1;
      a_sh  <= idx_shared;
      a_val <= value;
    end
  end

  // ring of cells; the head is cell 0, each cell takes its upper neighbor
  for (genvar j = 0; j < B_ENTRIES; j++) begin : g_cell
    skr_cell u_cell (
      .clk      (clk),
      .load     (load_go && (count == CW'(j))),
      .shift    (shift),
      .load_in  (new_entry),
      .shift_in (ring[(j + 1) % B_ENTRIES]),
      .entry    (ring[j])
    );
  end

  // compare the head entry against the held shared index
  assign tap.hit = shift && (step < count) && (ring[0].sh == a_sh);
  assign tap.fin = scan && (step == CW'(B_ENTRIES));

  skr_join u_join (
    .clk            (clk),
    .rst            (rst),
    .tap            (tap),
    .head           (ring[0]),
    .a_m0           (a_m0),
    .a_m1           (a_m1),
    .a_sh           (a_sh),
    .a_val          (a_val),
    .dim0           (dim0),
    .dim1           (dim1),
    .drained        (drained),
    .valid          (valid),
    .out_idx_mode0  (out_idx_mode0),
    .out_idx_mode1  (out_idx_mode1),
    .out_idx_shared (out_idx_shared),
    .out_value      (out_value),
    .last           (last)
  );

  // scanning always lies inside a busy period
  a_scan_busy: assert property (@(posedge clk) disable iff (rst) scan |-> busy)
    else $error("scan active while idle");

  // results only come out of an A item in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (rst) valid |-> $past(busy))
    else $error("result strobe outside an A item");

  // the fill count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(B_ENTRIES))
    else $error("entry count beyond capacity");

  // busy falls only on the flush slot leaving the pipeline
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(drained))
    else $error("busy dropped before flush");

endmodule

>>> bench/sparse_khatri_rao_join_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_khatri_rao_join_core_tb
// Self-checking bench for the sparse Khatri-Rao join core. B nonzeros are
// loaded and A nonzeros presented through the start/busy command port, with
// random idle gaps and one long stretch without them. A scoreboard keeps its
// own copy of the B store and the dimension registers, predicts every joined
// product in load order and checks each strobed result field by field.
// Directed transfers cover value and index extremes, saturation, rounding of
// negative products, no-match and empty-store scans, dimension zero and index
// wrap. Random phases then fill the store past capacity under several
// dimension settings.
// ----------------------------------------------------------------------------
module sparse_khatri_rao_join_core_tb;

  localparam int IDX_BITS      = skr_pkg::IDX_BITS;
  localparam int VAL_BITS      = skr_pkg::VAL_BITS;
  localparam int DIM_BITS      = skr_pkg::DIM_BITS;
  localparam int OUT_IDX_BITS  = skr_pkg::OUT_IDX_BITS;
  localparam int STORE_DEPTH   = skr_pkg::B_ENTRIES_DEF;
  localparam int SCAN_CYCLES   = STORE_DEPTH + 3;
  localparam int SETTLE_CYCLES = SCAN_CYCLES + 8;
  localparam int STALL_LIMIT   = 1000;
  localparam int GAP_PERCENT   = 27;
  localparam int PHASE_ITEMS   = 70;

  // one joined product as the core should strobe it
  typedef struct packed {
    logic [OUT_IDX_BITS-1:0]    m0;
    logic [OUT_IDX_BITS-1:0]    m1;
    logic [IDX_BITS-1:0]        sh;
    logic signed [VAL_BITS-1:0] val;
    logic                       last;
  } product_t;

  // Scoreboard: mirrors the B store and dimensions, queues predicted products
  class kr_join_book;
    logic [DIM_BITS-1:0] dim0;
    logic [DIM_BITS-1:0] dim1;
    skr_pkg::entry_t     b_store[STORE_DEPTH];
    int                  b_stored;
    product_t            due[$];
    int                  errors;

    function new();
      dim0     = DIM_BITS'(1);
      dim1     = DIM_BITS'(1);
      b_stored = 0;
      errors   = 0;
    endfunction

    function void set_dim(input logic idx, input logic [DIM_BITS-1:0] d);
      if (idx == skr_pkg::REG_DIM_MODE0) begin
        dim0 = d;
      end else begin
        dim1 = d;
      end
    endfunction

    // a * dim + b, wrapped to 32 bits
    function logic [OUT_IDX_BITS-1:0] combine(input logic [IDX_BITS-1:0] a,
                                              input logic [DIM_BITS-1:0] d,
                                              input logic [IDX_BITS-1:0] b);
      logic [63:0] wide;
      wide = {48'd0, a} * {47'd0, d} + {48'd0, b};
      return wide[OUT_IDX_BITS-1:0];
    endfunction

    // Q16.16 multiply: floor shift by 16, clamp to 32 bits
    function logic signed [VAL_BITS-1:0] q16_product(input logic signed [VAL_BITS-1:0] a,
                                                     input logic signed [VAL_BITS-1:0] b);
      logic signed [63:0] wa;
      logic signed [63:0] wb;
      logic signed [63:0] shifted;
      wa = a;
      wb = b;
      shifted = (wa * wb) >>> 16;
      if (shifted[63:31] == '0 || shifted[63:31] == '1) begin
        return shifted[VAL_BITS-1:0];
      end else if (shifted[63]) begin
        return 32'sh8000_0000;
      end else begin
        return 32'sh7FFF_FFFF;
      end
    endfunction

    // Note one accepted transfer: store a load, or predict the products of a scan
    function void take_item(input logic o, input logic [IDX_BITS-1:0] a0,
                            input logic [IDX_BITS-1:0] a1, input logic [IDX_BITS-1:0] s,
                            input logic signed [VAL_BITS-1:0] v);
      product_t r;
      int       hits;
      int       k;
      if (o == skr_pkg::OP_LOAD) begin
        // drop loads once the store is full
        if (b_stored < STORE_DEPTH) begin
          b_store[b_stored].m0  = a0;
          b_store[b_stored].m1  = a1;
          b_store[b_stored].sh  = s;
          b_store[b_stored].val = v;
          b_stored++;
        end
        return;
      end
      hits = 0;
      for (int j = 0; j < b_stored; j++) begin
        if (b_store[j].sh == s) hits++;
      end
      k = 0;
      for (int j = 0; j < b_stored; j++) begin
        if (b_store[j].sh == s) begin
          r.m0   = combine(a0, dim0, b_store[j].m0);
          r.m1   = combine(a1, dim1, b_store[j].m1);
          r.sh   = s;
          r.val  = q16_product(v, b_store[j].val);
          r.last = (k == hits - 1);
          due.push_back(r);
          k++;
        end
      end
    endfunction

    function int outstanding();
      return due.size();
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one strobed result with the oldest prediction
    task check_product(input logic [OUT_IDX_BITS-1:0] m0, input logic [OUT_IDX_BITS-1:0] m1,
                       input logic [IDX_BITS-1:0] sh, input logic signed [VAL_BITS-1:0] val,
                       input logic lst);
      product_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("unexpected result m0=%h m1=%h sh=%h val=%h last=%b",
                                  m0, m1, sh, val, lst));
      end else begin
        want = due.pop_front();
        if (m0 !== want.m0)
          report_mismatch($sformatf("out_idx_mode0 got %h want %h", m0, want.m0));
        if (m1 !== want.m1)
          report_mismatch($sformatf("out_idx_mode1 got %h want %h", m1, want.m1));
        if (sh !== want.sh)
          report_mismatch($sformatf("out_idx_shared got %h want %h", sh, want.sh));
        if (val !== want.val)
          report_mismatch($sformatf("out_value got %h want %h", val, want.val));
        if (lst !== want.last)
          report_mismatch($sformatf("last got %b want %b", lst, want.last));
      end
    endtask

    task close_out();
      if (due.size() != 0)
        report_mismatch($sformatf("%0d expected results never arrived", due.size()));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wr_en;
  logic                       cfg_index;
  logic [DIM_BITS-1:0]        cfg_data;
  logic                       start;
  logic                       busy;
  logic                       op;
  logic [IDX_BITS-1:0]        idx_mode0;
  logic [IDX_BITS-1:0]        idx_mode1;
  logic [IDX_BITS-1:0]        idx_shared;
  logic signed [VAL_BITS-1:0] value;
  logic                       valid;
  logic [OUT_IDX_BITS-1:0]    out_idx_mode0;
  logic [OUT_IDX_BITS-1:0]    out_idx_mode1;
  logic [IDX_BITS-1:0]        out_idx_shared;
  logic signed [VAL_BITS-1:0] out_value;
  logic                       last;

  kr_join_book book;
  bit          gaps_on;
  int          quiet_cycles;

  sparse_khatri_rao_join_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .idx_mode0      (idx_mode0),
    .idx_mode1      (idx_mode1),
    .idx_shared     (idx_shared),
    .value          (value),
    .valid          (valid),
    .out_idx_mode0  (out_idx_mode0),
    .out_idx_mode1  (out_idx_mode1),
    .out_idx_shared (out_idx_shared),
    .out_value      (out_value),
    .last           (last)
  );

  always #4 clk = ~clk;

  // Check every strobed result
  always @(posedge clk) begin
    if (!rst && valid) begin
      book.check_product(out_idx_mode0, out_idx_mode1, out_idx_shared, out_value, last);
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Drive one command and hold it until the core takes it
  task automatic send_item(input logic o, input logic [IDX_BITS-1:0] a0,
                           input logic [IDX_BITS-1:0] a1, input logic [IDX_BITS-1:0] s,
                           input logic [VAL_BITS-1:0] v);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, SCAN_CYCLES + 4)
                                        : $urandom_range(1, 3);
    end
    @(negedge clk);
    while (gap > 0) begin
      start = 1'b0;
      gap--;
      @(negedge clk);
    end
    start      = 1'b1;
    op         = o;
    idx_mode0  = a0;
    idx_mode1  = a1;
    idx_shared = s;
    value      = v;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.take_item(o, a0, a1, s, v);
  endtask

  // Stop sending and wait until every predicted result is in and the core is quiet
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_dim(input logic idx, input logic [DIM_BITS-1:0] d);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(posedge clk);
    book.set_dim(idx, d);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [IDX_BITS-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return IDX_BITS'($urandom_range(0, 65535));
  endfunction

  // favor a small pool of shared indices so scans find matches
  function automatic logic [IDX_BITS-1:0] pick_shared();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return IDX_BITS'($urandom_range(0, 5));
    if (r < 75) return '0;
    if (r < 80) return '1;
    return IDX_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic logic [VAL_BITS-1:0] pick_value();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      v = $urandom;
    end else if (r < 70) begin
      v = $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
    end else if (r < 76) begin
      v = 32'h7FFF_FFFF;
    end else if (r < 82) begin
      v = 32'h8000_0000;
    end else if (r < 88) begin
      v = 32'hFFFF_FFFF;
    end else if (r < 92) begin
      v = '0;
    end else begin
      v = $urandom_range(1, 255);
    end
    return v;
  endfunction

  function automatic logic [DIM_BITS-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 17'd1;
      2: return 17'd65536;
      3: return '1;
      4: return DIM_BITS'($urandom_range(1, 300));
      default: return DIM_BITS'($urandom_range(0, 131071));
    endcase
  endfunction

  // Random mix of loads and scans; dropped loads do not count
  task automatic random_phase(input int items, input bit calm);
    int   done;
    logic o;
    done    = 0;
    gaps_on = !calm;
    while (done < items) begin
      if (book.b_stored < STORE_DEPTH) begin
        o = ($urandom_range(0, 99) < 45) ? skr_pkg::OP_LOAD : skr_pkg::OP_PRESENT;
      end else begin
        o = ($urandom_range(0, 99) < 5) ? skr_pkg::OP_LOAD : skr_pkg::OP_PRESENT;
      end
      if (o == skr_pkg::OP_PRESENT || book.b_stored < STORE_DEPTH) done++;
      send_item(o, pick_index(), pick_index(), pick_shared(), pick_value());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    book       = new();
    rst        = 1'b1;
    cfg_wr_en  = 1'b0;
    cfg_index  = skr_pkg::REG_DIM_MODE0;
    cfg_data   = '0;
    start      = 1'b0;
    op         = skr_pkg::OP_LOAD;
    idx_mode0  = '0;
    idx_mode1  = '0;
    idx_shared = '0;
    value      = '0;
    gaps_on    = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // scan of an empty store yields nothing
    send_item(skr_pkg::OP_PRESENT, 16'hFFFF, 16'hFFFF, 16'h0000, 32'h0001_0000);

    // load extremes of index and value
    send_item(skr_pkg::OP_LOAD, 16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
    send_item(skr_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF, 16'h0000, 32'h8000_0000);
    send_item(skr_pkg::OP_LOAD, 16'd1234, 16'd4321, 16'hFFFF, 32'h0001_0000);
    send_item(skr_pkg::OP_LOAD, 16'h5555, 16'hAAAA, 16'h0000, 32'hFFFF_0000);
    send_item(skr_pkg::OP_LOAD, 16'hAAAA, 16'h5555, 16'hFFFF, 32'h0000_0001);

    // saturate both ways, round negative products down, miss, zero value
    send_item(skr_pkg::OP_PRESENT, 16'hFFFF, 16'hFFFF, 16'h0000, 32'h7FFF_FFFF);
    send_item(skr_pkg::OP_PRESENT, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000);
    send_item(skr_pkg::OP_PRESENT, 16'h5555, 16'hAAAA, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(skr_pkg::OP_PRESENT, 16'hAAAA, 16'h5555, 16'h1234, 32'h0002_0000);
    send_item(skr_pkg::OP_PRESENT, 16'h0001, 16'h0002, 16'h0000, 32'h0000_0000);
    drain();

    // zero dimension gives b alone; full 17-bit dimension wraps the index
    write_dim(skr_pkg::REG_DIM_MODE0, '0);
    write_dim(skr_pkg::REG_DIM_MODE1, '1);
    send_item(skr_pkg::OP_PRESENT, 16'hFFFF, 16'hFFFF, 16'h0000, 32'h0001_8000);
    send_item(skr_pkg::OP_PRESENT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFE_8000);
    drain();

    write_dim(skr_pkg::REG_DIM_MODE0, 17'd65536);
    write_dim(skr_pkg::REG_DIM_MODE1, 17'd65536);
    send_item(skr_pkg::OP_PRESENT, 16'hFFFF, 16'h0001, 16'h0000, 32'h0000_8000);
    send_item(skr_pkg::OP_PRESENT, 16'h8000, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
    drain();

    // random phases, each under fresh dimensions; the third runs without gaps
    for (int ph = 0; ph < 5; ph++) begin
      write_dim(skr_pkg::REG_DIM_MODE0, pick_dim());
      write_dim(skr_pkg::REG_DIM_MODE1, pick_dim());
      random_phase(PHASE_ITEMS, ph == 2);
      drain();
    end

    book.close_out();
    if (book.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
